// ===== hw/rtl/ber_pkg.sv =====
// ----------------------------------------------------------------------------
// ber_pkg: shared definitions for the box effective radius unit
// Widths, constants, mode codes and the side payloads that travel with the
// root pipelines.
// ----------------------------------------------------------------------------
package ber_pkg;

  // Side lengths and the radius are unsigned fixed point at this width.
  localparam int LENGTH_BITS = 32;
  // The root search covers one bit more than the length width.
  localparam int ROOT_BITS = LENGTH_BITS + 1;

  // Pi rounded to 32 fraction bits.
  localparam int PI_FRACTION_BITS = 32;
  localparam int PI_W = 34;
  localparam logic [PI_W-1:0] PI_Q = 34'h3_243F_6A89;

  // Square root datapath: scale factor width and residual width.
  localparam int SQ_K_W = PI_W;
  localparam int SQ_W = 104;

  // Cube root datapath: scale factor width and residual width.
  localparam int CB_K_W = PI_FRACTION_BITS + 6;
  localparam int CB_W = 144;

  typedef logic [LENGTH_BITS-1:0] len_t;
  typedef logic [ROOT_BITS-1:0] root_t;
  typedef logic [3:0] mode_t;

  // Radius definitions. Every code not listed selects the cylinder radius.
  localparam mode_t MODE_SPHERE    = 4'd2;
  localparam mode_t MODE_HALF_A    = 4'd3;
  localparam mode_t MODE_HALF_B    = 4'd4;
  localparam mode_t MODE_HALF_C    = 4'd5;
  localparam mode_t MODE_CIRCLE_AB = 4'd6;
  localparam mode_t MODE_DIAG_AB   = 4'd7;
  localparam mode_t MODE_DIAG_ABC  = 4'd8;

  // Fields that ride along the square root pipeline.
  typedef struct packed {
    mode_t       mode;
    len_t        a;
    len_t        b;
    len_t        c;
    len_t        len;
    logic [63:0] pp_lo;
    logic [63:0] pp_hi;
  } sq_side_t;

  // Fields that ride along the cylinder chain and the cube root pipeline.
  typedef struct packed {
    mode_t mode;
    len_t  a;
    len_t  b;
    len_t  c;
    root_t rs;
  } cb_side_t;

endpackage

// ===== hw/rtl/ber_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// ber_sqrt_pipe: pipelined scaled square root
// Finds the largest R with R*R*K <= X, one result bit per register stage.
// ----------------------------------------------------------------------------
module ber_sqrt_pipe import ber_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_x,
  input  logic [SQ_K_W-1:0] in_k,
  input  sq_side_t          in_side,
  output logic              out_valid,
  output root_t             out_root,
  output sq_side_t          out_side
);

  // Per stage: residual X - K*R^2, running K*R, partial root.
  logic              v_q    [0:ROOT_BITS-1];
  logic [SQ_W-1:0]   e_q    [0:ROOT_BITS-1];
  logic [SQ_W-1:0]   a_q    [0:ROOT_BITS-1];
  logic [SQ_K_W-1:0] k_q    [0:ROOT_BITS-1];
  root_t             r_q    [0:ROOT_BITS-1];
  sq_side_t          side_q [0:ROOT_BITS-1];

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_stage
    localparam int BIT = ROOT_BITS - 1 - g;
    logic              src_v;
    logic [SQ_W-1:0]   src_e;
    logic [SQ_W-1:0]   src_a;
    logic [SQ_K_W-1:0] src_k;
    root_t             src_r;
    sq_side_t          src_side;
    logic [SQ_W-1:0]   trial;
    logic              take;

    if (g == 0) begin : g_first
      assign src_v    = in_valid;
      assign src_e    = in_x;
      assign src_a    = '0;
      assign src_k    = in_k;
      assign src_r    = '0;
      assign src_side = in_side;
    end else begin : g_next
      assign src_v    = v_q[g-1];
      assign src_e    = e_q[g-1];
      assign src_a    = a_q[g-1];
      assign src_k    = k_q[g-1];
      assign src_r    = r_q[g-1];
      assign src_side = side_q[g-1];
    end

    // Growth of K*R^2 when this bit is set: 2*K*R*2^b + K*4^b.
    assign trial = (src_a << (BIT + 1)) + (SQ_W'(src_k) << (2 * BIT));
    assign take  = (trial <= src_e);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[g] <= 1'b0;
      end else if (en) begin
        v_q[g] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        e_q[g]    <= take ? (src_e - trial) : src_e;
        a_q[g]    <= take ? (src_a + (SQ_W'(src_k) << BIT)) : src_a;
        r_q[g]    <= take ? (src_r | (ROOT_BITS'(1) << BIT)) : src_r;
        k_q[g]    <= src_k;
        side_q[g] <= src_side;
      end
    end
  end

  assign out_valid = v_q[ROOT_BITS-1];
  assign out_root  = r_q[ROOT_BITS-1];
  assign out_side  = side_q[ROOT_BITS-1];

endmodule

// ===== hw/rtl/ber_cbrt_pipe.sv =====
// ----------------------------------------------------------------------------
// ber_cbrt_pipe: pipelined scaled cube root
// Finds the largest R with R*R*R*K <= X, one result bit per register stage.
// ----------------------------------------------------------------------------
module ber_cbrt_pipe import ber_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [CB_W-1:0]   in_x,
  input  logic [CB_K_W-1:0] in_k,
  input  cb_side_t          in_side,
  output logic              out_valid,
  output root_t             out_root,
  output cb_side_t          out_side
);

  // Per stage: residual X - K*R^3, running K*R^2 and K*R, partial root.
  logic              v_q    [0:ROOT_BITS-1];
  logic [CB_W-1:0]   e_q    [0:ROOT_BITS-1];
  logic [CB_W-1:0]   b_q    [0:ROOT_BITS-1];
  logic [CB_W-1:0]   a_q    [0:ROOT_BITS-1];
  logic [CB_K_W-1:0] k_q    [0:ROOT_BITS-1];
  root_t             r_q    [0:ROOT_BITS-1];
  cb_side_t          side_q [0:ROOT_BITS-1];

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_stage
    localparam int BIT = ROOT_BITS - 1 - g;
    logic              src_v;
    logic [CB_W-1:0]   src_e;
    logic [CB_W-1:0]   src_b;
    logic [CB_W-1:0]   src_a;
    logic [CB_K_W-1:0] src_k;
    root_t             src_r;
    cb_side_t          src_side;
    logic [CB_W-1:0]   k_ext;
    logic [CB_W-1:0]   trial;
    logic              take;

    if (g == 0) begin : g_first
      assign src_v    = in_valid;
      assign src_e    = in_x;
      assign src_b    = '0;
      assign src_a    = '0;
      assign src_k    = in_k;
      assign src_r    = '0;
      assign src_side = in_side;
    end else begin : g_next
      assign src_v    = v_q[g-1];
      assign src_e    = e_q[g-1];
      assign src_b    = b_q[g-1];
      assign src_a    = a_q[g-1];
      assign src_k    = k_q[g-1];
      assign src_r    = r_q[g-1];
      assign src_side = side_q[g-1];
    end

    // Growth of K*R^3 when this bit is set: 3*K*R^2*2^b + 3*K*R*4^b + K*8^b.
    assign k_ext = CB_W'(src_k);
    assign trial = (src_b << BIT) + (src_b << (BIT + 1))
                 + (src_a << (2 * BIT)) + (src_a << (2 * BIT + 1))
                 + (k_ext << (3 * BIT));
    assign take  = (trial <= src_e);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[g] <= 1'b0;
      end else if (en) begin
        v_q[g] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        e_q[g]    <= take ? (src_e - trial) : src_e;
        b_q[g]    <= take ? (src_b + (src_a << (BIT + 1)) + (k_ext << (2 * BIT))) : src_b;
        a_q[g]    <= take ? (src_a + (k_ext << BIT)) : src_a;
        r_q[g]    <= take ? (src_r | (ROOT_BITS'(1) << BIT)) : src_r;
        k_q[g]    <= src_k;
        side_q[g] <= src_side;
      end
    end
  end

  assign out_valid = v_q[ROOT_BITS-1];
  assign out_root  = r_q[ROOT_BITS-1];
  assign out_side  = side_q[ROOT_BITS-1];

endmodule

// ===== hw/rtl/box_effective_radius_unit.sv =====
// ----------------------------------------------------------------------------
// box_effective_radius_unit: effective radius of a rectangular box
// Takes a mode and three Q16.16 side lengths, returns one Q16.16 radius.
// ----------------------------------------------------------------------------
// The unit accepts one item per clock cycle while the output side is taking
// results, and returns the results in order. Each item passes through the two
// bit-serial root pipelines (33 stages for the square root, 33 for the cube
// root) plus eleven stages for sorting, products and the cylinder volume and
// one output register. When the output is not taken, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated. Modes 2 to 8 select the
// sphere, half-side, face circle and half-diagonal radii; every other mode
// gives the excluded-volume cylinder radius. A radius beyond the output range
// reads as all ones with the saturated flag set.
module box_effective_radius_unit import ber_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // Fields from bit 0 up: side_a, side_b, side_c.
  input  logic [3*LENGTH_BITS-1:0] s_tdata,
  // Fields from bit 0 up: mode.
  input  mode_t                    s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // Fields from bit 0 up: radius.
  output len_t                     m_tdata,
  // Fields from bit 0 up: saturated.
  output logic [0:0]               m_tuser
);

  localparam int PT_SPLIT  = 34;
  localparam int VOL_SPLIT = 34;

  logic en;

  // The pipeline advances whenever the output register can take a new item.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage valid bits.
  logic v0, v1, v2, v3, v4, v5, v6, v7, v8, v9, v10;
  logic vs, vc;

  // Front stages.
  mode_t mode0, mode1, mode2, mode3;
  len_t  a0, b0, c0, a1, b1, c1, a2, b2, c2, a3, b3, c3;
  len_t  lo1, mid1, hi1, lo_next, mid_next, hi_next;
  len_t  p2, q2, len2, len3, p_next, q_next, len_next;
  logic        use_big;
  logic [63:0] m3, sqa3, sqb3, sqc3;
  logic [SQ_W-1:0]   x4, x_next;
  logic [SQ_K_W-1:0] k4, k_next;
  sq_side_t          side4;

  // Square root outputs.
  root_t    rs;
  sq_side_t sides;

  // Cylinder volume chain.
  cb_side_t    pass5, pass6, pass7, pass8, pass9;
  len_t        r5, len5, rs_low;
  logic [65:0] pr5;
  logic [63:0] rl5, rl6, rl7;
  logic [32:0] rpl5, rpl6;
  logic [95:0] abc5;
  logic [66:0] pt6;
  logic [33:0] r3_6, r3_7, r3_8;
  logic [97:0] abc3_6, abc3_7, abc3_8, abc3_9;
  logic [66:0] q0_7;
  logic [65:0] q1_7;
  logic [99:0] inner8;
  logic [67:0] v0_9, v1_9;
  logic [65:0] v2_9;
  logic [CB_W-1:0]   x10, cx_next;
  logic [CB_K_W-1:0] k10, ck_next;
  cb_side_t          pass10;

  // Cube root outputs and final selection.
  root_t    rc;
  cb_side_t cside;
  root_t    sel_next;

  // Valid bits travel with their items.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      v5       <= 1'b0;
      v6       <= 1'b0;
      v7       <= 1'b0;
      v8       <= 1'b0;
      v9       <= 1'b0;
      v10      <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v0       <= s_tvalid;
      v1       <= v0;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      v5       <= vs;
      v6       <= v5;
      v7       <= v6;
      v8       <= v7;
      v9       <= v8;
      v10      <= v9;
      m_tvalid <= vc;
    end
  end

  // Sort the three sides into ascending order.
  always_comb begin
    len_t t;
    t        = '0;
    lo_next  = a0;
    mid_next = b0;
    hi_next  = c0;
    if (lo_next > mid_next) begin
      t        = lo_next;
      lo_next  = mid_next;
      mid_next = t;
    end
    if (mid_next > hi_next) begin
      t        = mid_next;
      mid_next = hi_next;
      hi_next  = t;
    end
    if (lo_next > mid_next) begin
      t        = lo_next;
      lo_next  = mid_next;
      mid_next = t;
    end
  end

  // Pick the face to square-root and the length; the closer pair of sides
  // forms the cylinder cross-section.
  assign use_big = (mid1 - lo1) > (hi1 - mid1);

  always_comb begin
    p_next   = a1;
    q_next   = b1;
    len_next = hi1;
    case (mode1)
      MODE_SPHERE, MODE_CIRCLE_AB: begin
        p_next = a1;
        q_next = b1;
      end
      default: begin
        if (use_big) begin
          p_next   = mid1;
          q_next   = hi1;
          len_next = lo1;
        end else begin
          p_next   = lo1;
          q_next   = mid1;
          len_next = hi1;
        end
      end
    endcase
  end

  // Square root operand and scale for each mode.
  always_comb begin
    case (mode3)
      MODE_DIAG_AB: begin
        x_next = SQ_W'(sqa3) + SQ_W'(sqb3);
        k_next = SQ_K_W'(1);
      end
      MODE_DIAG_ABC: begin
        x_next = SQ_W'(sqa3) + SQ_W'(sqb3) + SQ_W'(sqc3);
        k_next = SQ_K_W'(1);
      end
      default: begin
        x_next = SQ_W'(m3) << PI_FRACTION_BITS;
        k_next = PI_Q;
      end
    endcase
  end

  // Front stage registers: capture, sort, select, multiply, operand.
  always_ff @(posedge clk) begin
    if (en) begin
      mode0 <= s_tuser;
      a0    <= s_tdata[LENGTH_BITS-1:0];
      b0    <= s_tdata[2*LENGTH_BITS-1:LENGTH_BITS];
      c0    <= s_tdata[3*LENGTH_BITS-1:2*LENGTH_BITS];

      mode1 <= mode0;
      a1    <= a0;
      b1    <= b0;
      c1    <= c0;
      lo1   <= lo_next;
      mid1  <= mid_next;
      hi1   <= hi_next;

      mode2 <= mode1;
      a2    <= a1;
      b2    <= b1;
      c2    <= c1;
      p2    <= p_next;
      q2    <= q_next;
      len2  <= len_next;

      mode3 <= mode2;
      a3    <= a2;
      b3    <= b2;
      c3    <= c2;
      len3  <= len2;
      m3    <= 64'(p2) * 64'(q2);
      sqa3  <= 64'(a2) * 64'(a2);
      sqb3  <= 64'(b2) * 64'(b2);
      sqc3  <= 64'(c2) * 64'(c2);

      x4          <= x_next;
      k4          <= k_next;
      side4.mode  <= mode3;
      side4.a     <= a3;
      side4.b     <= b3;
      side4.c     <= c3;
      side4.len   <= len3;
      side4.pp_lo <= 64'(m3[31:0]) * 64'(c3);
      side4.pp_hi <= 64'(m3[63:32]) * 64'(c3);
    end
  end

  ber_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .in_x      (x4),
    .in_k      (k4),
    .in_side   (side4),
    .out_valid (vs),
    .out_root  (rs),
    .out_side  (sides)
  );

  // The face circle radius is below 2^32, so its low bits carry it.
  assign rs_low = rs[LENGTH_BITS-1:0];

  // Cube root operand and scale: sphere volume or cylinder excluded volume.
  always_comb begin
    case (pass9.mode)
      MODE_SPHERE: begin
        cx_next = CB_W'(abc3_9) << PI_FRACTION_BITS;
        ck_next = CB_K_W'({PI_Q, 2'b00});
      end
      default: begin
        cx_next = CB_W'(v0_9) + (CB_W'(v1_9) << VOL_SPLIT)
                + (CB_W'(v2_9) << (2 * VOL_SPLIT));
        ck_next = CB_K_W'(1) << (PI_FRACTION_BITS + 5);
      end
    endcase
  end

  // Cylinder chain: pi term, inner sum, volume, cut into partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      pass5.mode <= sides.mode;
      pass5.a    <= sides.a;
      pass5.b    <= sides.b;
      pass5.c    <= sides.c;
      pass5.rs   <= rs;
      r5         <= rs_low;
      len5       <= sides.len;
      pr5        <= 66'(PI_Q) * 66'(rs_low);
      rl5        <= 64'(rs_low) * 64'(sides.len);
      rpl5       <= 33'(rs_low) + 33'(sides.len);
      abc5       <= 96'(sides.pp_lo) + (96'(sides.pp_hi) << 32);

      pass6  <= pass5;
      pt6    <= 67'(pr5) + (67'(len5) << PI_FRACTION_BITS);
      rl6    <= rl5;
      rpl6   <= rpl5;
      r3_6   <= 34'(r5) + (34'(r5) << 1);
      abc3_6 <= 98'(abc5) + (98'(abc5) << 1);

      pass7  <= pass6;
      q0_7   <= 67'(rpl6) * 67'(pt6[PT_SPLIT-1:0]);
      q1_7   <= 66'(rpl6) * 66'(pt6[66:PT_SPLIT]);
      rl7    <= rl6;
      r3_7   <= r3_6;
      abc3_7 <= abc3_6;

      pass8  <= pass7;
      inner8 <= (100'(rl7) << (PI_FRACTION_BITS + 1)) + 100'(q0_7)
              + (100'(q1_7) << PT_SPLIT);
      r3_8   <= r3_7;
      abc3_8 <= abc3_7;

      pass9  <= pass8;
      v0_9   <= 68'(r3_8) * 68'(inner8[VOL_SPLIT-1:0]);
      v1_9   <= 68'(r3_8) * 68'(inner8[2*VOL_SPLIT-1:VOL_SPLIT]);
      v2_9   <= 66'(r3_8) * 66'(inner8[99:2*VOL_SPLIT]);
      abc3_9 <= abc3_8;

      pass10 <= pass9;
      x10    <= cx_next;
      k10    <= ck_next;
    end
  end

  ber_cbrt_pipe u_cbrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v10),
    .in_x      (x10),
    .in_k      (k10),
    .in_side   (pass10),
    .out_valid (vc),
    .out_root  (rc),
    .out_side  (cside)
  );

  // Final radius for each mode.
  always_comb begin
    case (cside.mode)
      MODE_SPHERE:                 sel_next = rc;
      MODE_HALF_A:                 sel_next = ROOT_BITS'(cside.a >> 1);
      MODE_HALF_B:                 sel_next = ROOT_BITS'(cside.b >> 1);
      MODE_HALF_C:                 sel_next = ROOT_BITS'(cside.c >> 1);
      MODE_CIRCLE_AB:              sel_next = cside.rs;
      MODE_DIAG_AB, MODE_DIAG_ABC: sel_next = cside.rs >> 1;
      default:                     sel_next = rc;
    endcase
  end

  // Output register with saturation.
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata    <= sel_next[ROOT_BITS-1] ? '1 : sel_next[LENGTH_BITS-1:0];
      m_tuser[0] <= sel_next[ROOT_BITS-1];
    end
  end

endmodule

// ===== hw/rtl/ber_checker.sv =====
// ----------------------------------------------------------------------------
// ber_port_checker: port-level checks for the box effective radius unit
// Watches the stream ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
module ber_port_checker import ber_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input len_t                     m_tdata,
  input logic [0:0]               m_tuser
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // The input side moves exactly when the output register can move.
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow the output side");

  // A stalled result stays put.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // A saturated result reads as all ones.
  a_sat_ones: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '1)
    else $error("saturated result is not all ones");

endmodule

bind box_effective_radius_unit ber_port_checker u_ber_port_checker (.*);

// ===== test/ber_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ber_checker: radius predictor and result scoreboard
// Watches both streams of the box effective radius unit, works out the radius
// of every accepted box and compares it with the results in arrival order.
// ----------------------------------------------------------------------------
module ber_checker import ber_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  // Fields from bit 0 up: side_a, side_b, side_c.
  input  logic [3*LENGTH_BITS-1:0] s_tdata,
  // Fields from bit 0 up: mode.
  input  mode_t                    s_tuser,
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  // Fields from bit 0 up: radius.
  input  len_t                     m_tdata,
  // Fields from bit 0 up: saturated.
  input  logic [0:0]               m_tuser,
  output int                       fail_count,
  output int                       pending
);

  typedef logic [255:0] wide_t;

  typedef struct {
    len_t radius;
    logic saturated;
  } radius_item_t;

  radius_item_t radius_queue[$];

  assign pending = radius_queue.size();

  // Largest root R with R^power * k <= x, searched one bit at a time.
  function automatic wide_t int_root(int power, wide_t k, wide_t x);
    wide_t r;
    wide_t cand;
    wide_t p;
    r = '0;
    for (int b = ROOT_BITS - 1; b >= 0; b--) begin
      cand = r | (wide_t'(1) << b);
      p = cand * k;
      for (int i = 1; i < power; i++) p = p * cand;
      if (p <= x) r = cand;
    end
    return r;
  endfunction

  // Radius of the circle whose area is p*q.
  function automatic wide_t disc_radius(wide_t p, wide_t q);
    return int_root(2, wide_t'(PI_Q), (p * q) << PI_FRACTION_BITS);
  endfunction

  // Excluded-volume radius of the cylinder built from the sorted sides.
  function automatic wide_t cyl_radius(wide_t a, wide_t b, wide_t c);
    wide_t s1, s2, s3, t, r, len, pi_term, inner, vol;
    s1 = a;
    s2 = b;
    s3 = c;
    if (s1 > s2) begin t = s1; s1 = s2; s2 = t; end
    if (s2 > s3) begin t = s2; s2 = s3; s3 = t; end
    if (s1 > s2) begin t = s1; s1 = s2; s2 = t; end
    // The closer pair forms the cross-section.
    if (s2 - s1 > s3 - s2) begin
      r = disc_radius(s2, s3);
      len = s1;
    end else begin
      r = disc_radius(s1, s2);
      len = s3;
    end
    pi_term = wide_t'(PI_Q) * r + (len << PI_FRACTION_BITS);
    inner = ((r * len) << (PI_FRACTION_BITS + 1)) + (r + len) * pi_term;
    vol = (3 * r) * inner;
    return int_root(3, wide_t'(1) << (PI_FRACTION_BITS + 5), vol);
  endfunction

  function automatic radius_item_t box_radius(mode_t mode, len_t a, len_t b, len_t c);
    wide_t wa, wb, wc, r;
    radius_item_t res;
    wa = wide_t'(a);
    wb = wide_t'(b);
    wc = wide_t'(c);
    case (mode)
      MODE_SPHERE: begin
        r = int_root(3, 4 * wide_t'(PI_Q), ((3 * wa) * (wb * wc)) << PI_FRACTION_BITS);
      end
      MODE_HALF_A:    r = wa >> 1;
      MODE_HALF_B:    r = wb >> 1;
      MODE_HALF_C:    r = wc >> 1;
      MODE_CIRCLE_AB: r = disc_radius(wa, wb);
      MODE_DIAG_AB:   r = int_root(2, 1, wa * wa + wb * wb) >> 1;
      MODE_DIAG_ABC:  r = int_root(2, 1, wa * wa + wb * wb + wc * wc) >> 1;
      default:        r = cyl_radius(wa, wb, wc);
    endcase
    if (r > wide_t'({LENGTH_BITS{1'b1}})) begin
      res.radius = '1;
      res.saturated = 1'b1;
    end else begin
      res.radius = len_t'(r);
      res.saturated = 1'b0;
    end
    return res;
  endfunction

  initial fail_count = 0;

  // Predict on every accepted box and check every accepted result.
  always @(posedge clk) begin
    radius_item_t exp_item;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        radius_queue.push_back(box_radius(s_tuser, s_tdata[LENGTH_BITS-1:0],
                                          s_tdata[2*LENGTH_BITS-1:LENGTH_BITS],
                                          s_tdata[3*LENGTH_BITS-1:2*LENGTH_BITS]));
      end
      if (m_tvalid && m_tready) begin
        if (radius_queue.size() == 0) begin
          $error("unexpected result radius %h saturated %b", m_tdata, m_tuser);
          fail_count = fail_count + 1;
        end else begin
          exp_item = radius_queue.pop_front();
          if (m_tdata !== exp_item.radius) begin
            $error("radius: expected %h, actual %h", exp_item.radius, m_tdata);
            fail_count = fail_count + 1;
          end
          if (m_tuser[0] !== exp_item.saturated) begin
            $error("saturated: expected %b, actual %b", exp_item.saturated, m_tuser[0]);
            fail_count = fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== test/tb_box_effective_radius_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_effective_radius_unit: stream test of the box effective radius unit
// Sends directed boxes for every mode and the corner lengths, then random
// boxes with random gaps and output stalls; the checker scores the radii.
// ----------------------------------------------------------------------------
module tb_box_effective_radius_unit;
  import ber_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;

  logic                     clk;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [3*LENGTH_BITS-1:0] s_tdata;
  mode_t                    s_tuser;
  logic                     m_tvalid;
  logic                     m_tready;
  len_t                     m_tdata;
  logic [0:0]               m_tuser;
  int                       fail_count;
  int                       pending;
  int                       cycle_count;
  bit                       quiet;

  box_effective_radius_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  ber_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Guard against a hung pipeline.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_box_effective_radius_unit NOT OK");
      $finish;
    end
  end

  // Send one box after a random gap and wait until it is taken.
  task automatic send_box(mode_t mode, len_t a, len_t b, len_t c);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = mode;
    s_tdata = {c, b, a};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    @(negedge clk);
  endtask

  // Random side length, mostly moderate, sometimes tiny, zero or huge.
  function automatic len_t rand_side();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return len_t'($urandom_range(0, 255));
      2: return '1 - len_t'($urandom_range(0, 255));
      3: return $urandom;
      default: return len_t'($urandom_range(0, 32'h00FF_FFFF));
    endcase
  endfunction

  // Result side: random stall before each result.
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  initial begin
    len_t a, b, c;
    quiet = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero and full-scale sides in every mode.
    for (int m = 0; m < 16; m++) begin
      send_box(mode_t'(m), '0, '0, '0);
      send_box(mode_t'(m), '1, '1, '1);
    end
    // Both cylinder orientations, equal sides, then a sphere and a diagonal with extreme sides.
    send_box(4'd1, 32'h0001_0000, 32'h0009_0000, 32'h000A_0000);
    send_box(4'd1, 32'h0001_0000, 32'h0002_0000, 32'h0010_0000);
    send_box(4'd0, 32'h0030_0000, 32'h0001_0000, 32'h0002_0000);
    send_box(4'd15, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000);
    send_box(MODE_SPHERE, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0001);
    send_box(MODE_DIAG_ABC, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);

    // Random boxes, alternating bursts with and without idling.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = ((i / 100) % 2) == 1;
      a = rand_side();
      b = ($urandom_range(0, 3) == 0) ? a : rand_side();
      c = rand_side();
      send_box(mode_t'($urandom_range(0, 15)), a, b, c);
    end
    s_tvalid = 1'b0;

    // Drain the pipeline.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_box_effective_radius_unit OK");
    end else begin
      $display("tb_box_effective_radius_unit NOT OK");
    end
    $finish;
  end

endmodule
